>>> rtl/clip_frame_loop_pingpong_mapper_defines.svh
// assertion macros for the clip frame mapper checker
`ifndef CLIP_FRAME_LOOP_PINGPONG_MAPPER_DEFINES_SVH
`define CLIP_FRAME_LOOP_PINGPONG_MAPPER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define CFLPM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent a fixed number of cycles later
`define CFLPM_ASSERT_DELAY(lbl, clk, rst_n, ante, n, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error(msg);

`endif

>>> rtl/cflpm_pkg.sv
package cflpm_pkg;

    localparam int FRAME_BITS_DEF = 24;
    localparam int ADDR_BITS      = 5;
    localparam int DATA_BITS      = 32;

    typedef enum logic [2:0] {
        REG_IN_FRAME        = 3'd0,
        REG_OUT_FRAME       = 3'd1,
        REG_SLIP_OFFSET     = 3'd2,
        REG_LOOP_ENABLE     = 3'd3,
        REG_PINGPONG_ENABLE = 3'd4
    } cflpm_reg_t;

    typedef struct packed {
        logic loop_enable;
        logic pingpong_enable;
    } cflpm_mode_t;

    typedef struct packed {
        logic valid;
        logic neg;
        logic qbit;
        logic qnz;
    } cflpm_ctl_t;

endpackage

>>> rtl/cflpm_regs.sv
module cflpm_regs #(
    parameter int FRAME_BITS = cflpm_pkg::FRAME_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cflpm_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [cflpm_pkg::DATA_BITS-1:0]  pwdata,
    output logic [cflpm_pkg::DATA_BITS-1:0]  prdata,
    output logic [FRAME_BITS-1:0]            in_frame,
    output logic [FRAME_BITS-1:0]            out_frame,
    output logic [FRAME_BITS:0]              slip_offset,
    output cflpm_pkg::cflpm_mode_t           mode
);
    import cflpm_pkg::*;

    logic [FRAME_BITS-1:0] in_frame_reg, in_frame_next;
    logic [FRAME_BITS-1:0] out_frame_reg, out_frame_next;
    logic [FRAME_BITS:0]   slip_offset_reg, slip_offset_next;
    cflpm_mode_t           mode_reg, mode_next;
    cflpm_reg_t            reg_idx;
    logic                  wr_en;

    assign reg_idx = cflpm_reg_t'(paddr[ADDR_BITS-1:2]);
    assign wr_en   = psel && penable && pwrite;

    always_comb
    begin
        in_frame_next    = in_frame_reg;
        out_frame_next   = out_frame_reg;
        slip_offset_next = slip_offset_reg;
        mode_next        = mode_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_IN_FRAME:        in_frame_next = pwdata[FRAME_BITS-1:0];
                REG_OUT_FRAME:       out_frame_next = pwdata[FRAME_BITS-1:0];
                REG_SLIP_OFFSET:     slip_offset_next = pwdata[FRAME_BITS:0];
                REG_LOOP_ENABLE:     mode_next.loop_enable = pwdata[0];
                REG_PINGPONG_ENABLE: mode_next.pingpong_enable = pwdata[0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg    <= FRAME_BITS'(1);
            out_frame_reg   <= FRAME_BITS'(1);
            slip_offset_reg <= '0;
            mode_reg        <= '0;
        end
        else
        begin
            in_frame_reg    <= in_frame_next;
            out_frame_reg   <= out_frame_next;
            slip_offset_reg <= slip_offset_next;
            mode_reg        <= mode_next;
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_IN_FRAME:        prdata = DATA_BITS'(in_frame_reg);
            REG_OUT_FRAME:       prdata = DATA_BITS'(out_frame_reg);
            REG_SLIP_OFFSET:     prdata = DATA_BITS'(slip_offset_reg);
            REG_LOOP_ENABLE:     prdata = DATA_BITS'(mode_reg.loop_enable);
            REG_PINGPONG_ENABLE: prdata = DATA_BITS'(mode_reg.pingpong_enable);
            default:             prdata = '0;
        endcase
    end

    assign in_frame    = in_frame_reg;
    assign out_frame   = out_frame_reg;
    assign slip_offset = slip_offset_reg;
    assign mode        = mode_reg;

endmodule

>>> rtl/cflpm_div_stage.sv
module cflpm_div_stage #(
    parameter int FRAME_BITS = cflpm_pkg::FRAME_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [FRAME_BITS:0]   len,
    input  cflpm_pkg::cflpm_ctl_t ctl_in,
    input  logic [FRAME_BITS-1:0] rem_in,
    input  logic [FRAME_BITS:0]   mag_in,
    output cflpm_pkg::cflpm_ctl_t ctl_out,
    output logic [FRAME_BITS-1:0] rem_out,
    output logic [FRAME_BITS:0]   mag_out
);
    import cflpm_pkg::*;

    cflpm_ctl_t            ctl_reg, ctl_next;
    logic [FRAME_BITS-1:0] rem_reg, rem_next;
    logic [FRAME_BITS:0]   mag_reg, mag_next;
    logic [FRAME_BITS:0]   trial;
    logic [FRAME_BITS:0]   diff;
    logic                  ge;

    // one restoring step, dividend bits enter msb first
    assign trial = {rem_in, mag_in[FRAME_BITS]};
    assign ge    = (trial >= len);
    assign diff  = trial - len;

    always_comb
    begin
        rem_next      = ge ? diff[FRAME_BITS-1:0] : trial[FRAME_BITS-1:0];
        mag_next      = {mag_in[FRAME_BITS-1:0], 1'b0};
        ctl_next      = ctl_in;
        ctl_next.qbit = ge;
        ctl_next.qnz  = ctl_in.qnz | ge;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        mag_reg <= mag_next;
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign mag_out = mag_reg;

endmodule

>>> rtl/cflpm_map.sv
module cflpm_map #(
    parameter int FRAME_BITS = cflpm_pkg::FRAME_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cflpm_pkg::cflpm_ctl_t  ctl,
    input  logic [FRAME_BITS-1:0]  rem,
    input  logic [FRAME_BITS-1:0]  in_frame,
    input  logic [FRAME_BITS-1:0]  out_frame,
    input  cflpm_pkg::cflpm_mode_t mode,
    output logic                   done,
    output logic [FRAME_BITS-1:0]  clip_frame,
    output logic                   length_error
);
    import cflpm_pkg::*;

    logic                  done_reg;
    logic [FRAME_BITS-1:0] clip_frame_reg, clip_frame_next;
    logic                  length_error_reg, length_error_next;
    logic [FRAME_BITS-1:0] sum_in, dif_in, dif_out;
    logic [FRAME_BITS-1:0] base, pp_frame, loop_frame, clamp_frame;
    logic                  rneg, under, odd;

    assign sum_in  = in_frame + rem;
    assign dif_in  = in_frame - rem;
    assign dif_out = out_frame - rem;
    assign rneg    = ctl.neg && (rem != '0);
    assign under   = (rem > in_frame);

    always_comb
    begin
        if (rneg)
        begin
            base     = under ? dif_out : dif_in;
            odd      = ctl.qbit ^ under;
            pp_frame = sum_in;
        end
        else
        begin
            base     = sum_in;
            odd      = ctl.qbit;
            pp_frame = dif_out;
        end
        loop_frame = (mode.pingpong_enable && odd) ? pp_frame : base;

        if (ctl.neg)
        begin
            clamp_frame = in_frame;
        end
        else if (ctl.qnz)
        begin
            clamp_frame = out_frame;
        end
        else
        begin
            clamp_frame = sum_in;
        end

        length_error_next = (out_frame < in_frame);
        if (length_error_next)
        begin
            clip_frame_next = '0;
        end
        else
        begin
            clip_frame_next = mode.loop_enable ? loop_frame : clamp_frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        clip_frame_reg   <= clip_frame_next;
        length_error_reg <= length_error_next;
    end

    assign done         = done_reg;
    assign clip_frame   = clip_frame_reg;
    assign length_error = length_error_reg;

endmodule

>>> rtl/clip_frame_loop_pingpong_mapper.sv
// done pulses after a word passes the offset, sign, divider and map registers
// throughput: one word per cycle, set by the one-bit-per-stage divider pipeline
// busy stays low, a new word may be started every cycle; the receiver cannot stall
// reset: rst_n low clears all valid bits and loads the configuration registers with their reset values
module clip_frame_loop_pingpong_mapper #(
    parameter int FRAME_BITS = cflpm_pkg::FRAME_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cflpm_pkg::ADDR_BITS-1:0] paddr,
    input  logic [cflpm_pkg::DATA_BITS-1:0] pwdata,
    output logic [cflpm_pkg::DATA_BITS-1:0] prdata,
    output logic                            pready,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [FRAME_BITS:0]      timeline_frame,
    output logic                            done,
    output logic [FRAME_BITS-1:0]           clip_frame,
    output logic                            length_error
);
    import cflpm_pkg::*;

    localparam int DIV_STAGES = FRAME_BITS + 1;

    logic [FRAME_BITS-1:0] in_frame;
    logic [FRAME_BITS-1:0] out_frame;
    logic [FRAME_BITS:0]   slip_offset;
    cflpm_mode_t           mode;
    logic [FRAME_BITS:0]   len;

    logic                  s1_valid_reg;
    logic [FRAME_BITS+1:0] delta_reg, delta_next;
    cflpm_ctl_t            s2_ctl_reg, s2_ctl_next;
    logic [FRAME_BITS:0]   s2_mag_reg, s2_mag_next;
    logic [FRAME_BITS+1:0] delta_abs;

    cflpm_ctl_t            ctl_chain [0:DIV_STAGES];
    logic [FRAME_BITS-1:0] rem_chain [0:DIV_STAGES];
    logic [FRAME_BITS:0]   mag_chain [0:DIV_STAGES];

    assign pready = 1'b1;
    assign busy   = 1'b0;

    cflpm_regs #(.FRAME_BITS(FRAME_BITS)) u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .in_frame    (in_frame),
        .out_frame   (out_frame),
        .slip_offset (slip_offset),
        .mode        (mode)
    );

    assign len = {1'b0, out_frame} - {1'b0, in_frame} + (FRAME_BITS+1)'(1);

    // stage 1: offset into the clip
    assign delta_next = {timeline_frame[FRAME_BITS], timeline_frame}
                      - {slip_offset[FRAME_BITS], slip_offset};

    // stage 2: sign and magnitude
    assign delta_abs = delta_reg[FRAME_BITS+1] ? (~delta_reg + (FRAME_BITS+2)'(1)) : delta_reg;

    always_comb
    begin
        s2_ctl_next.valid = s1_valid_reg;
        s2_ctl_next.neg   = delta_reg[FRAME_BITS+1];
        s2_ctl_next.qbit  = 1'b0;
        s2_ctl_next.qnz   = 1'b0;
        s2_mag_next       = delta_abs[FRAME_BITS:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_ctl_reg   <= '0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            s2_ctl_reg   <= s2_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        delta_reg  <= delta_next;
        s2_mag_reg <= s2_mag_next;
    end

    assign ctl_chain[0] = s2_ctl_reg;
    assign rem_chain[0] = '0;
    assign mag_chain[0] = s2_mag_reg;

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        cflpm_div_stage #(.FRAME_BITS(FRAME_BITS)) u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .len     (len),
            .ctl_in  (ctl_chain[k]),
            .rem_in  (rem_chain[k]),
            .mag_in  (mag_chain[k]),
            .ctl_out (ctl_chain[k+1]),
            .rem_out (rem_chain[k+1]),
            .mag_out (mag_chain[k+1])
        );
    end

    cflpm_map #(.FRAME_BITS(FRAME_BITS)) u_map (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl_chain[DIV_STAGES]),
        .rem          (rem_chain[DIV_STAGES]),
        .in_frame     (in_frame),
        .out_frame    (out_frame),
        .mode         (mode),
        .done         (done),
        .clip_frame   (clip_frame),
        .length_error (length_error)
    );

endmodule

>>> rtl/cflpm_checker.sv
`include "clip_frame_loop_pingpong_mapper_defines.svh"

module cflpm_checker #(
    parameter int FRAME_BITS = cflpm_pkg::FRAME_BITS_DEF
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  done,
    input logic [FRAME_BITS-1:0] clip_frame,
    input logic                  length_error
);
    localparam int LAT = FRAME_BITS + 4;

    logic accept;

    assign accept = start && !busy;

    `CFLPM_ASSERT_DELAY(a_word_returns, clk, rst_n, accept, LAT, done, "accepted word not returned")
    `CFLPM_ASSERT_IMPL(a_no_spurious, clk, rst_n, done, $past(accept, LAT), "result without word")
    `CFLPM_ASSERT_IMPL(a_err_zero, clk, rst_n, done && length_error, clip_frame == '0, "error frame not zero")

endmodule

bind clip_frame_loop_pingpong_mapper cflpm_checker #(.FRAME_BITS(FRAME_BITS)) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .clip_frame   (clip_frame),
    .length_error (length_error)
);
